// ----- sv/bth_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_pkg
// shared types and constants of the block table heap allocator
// ----------------------------------------------------------------------------
package bth_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ADDR_W      = 39;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int TDATA_W     = ((ADDR_W + 7) / 8) * 8;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_MISS,
    S_DONE
  } state_e;

  // one row of the block table
  typedef struct packed {
    logic              free;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] address;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_e           status;
  } result_t;

endpackage

// ----- sv/bth_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bth_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/bth_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_ctrl
// request sequencer: scans the block table, updates it and forms the result
// ----------------------------------------------------------------------------
module bth_ctrl import bth_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ADDR_W-1:0] heap_base_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  opcode_e           in_opcode_i,
  input  logic [ADDR_W-1:0] in_operand_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output result_t           res_o,
  output ram_req_t          ram_req_o,
  input  entry_t            ram_rdata_i
);

  state_e            state_q, state_d;
  opcode_e           op_q, op_d;
  logic [ADDR_W-1:0] operand_q, operand_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] heap_end_q, heap_end_d;
  result_t           res_q, res_d;

  logic hit;
  logic last;
  logic full;

  assign full   = (count_q == CNT_W'(TABLE_DEPTH));
  assign last   = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  always_comb begin
    if (op_q == OP_ALLOC) begin
      hit = ram_rdata_i.free && (ram_rdata_i.size >= operand_q);
    end else begin
      hit = (ram_rdata_i.address == operand_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (count_q == '0) ? S_MISS : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = S_DONE;
        end else if (last) begin
          state_d = S_MISS;
        end
      end
      S_MISS: state_d = S_DONE;
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o      = 1'b0;
    res_valid_o     = 1'b0;
    op_d            = op_q;
    operand_d       = operand_q;
    idx_d           = idx_q;
    count_d         = count_q;
    heap_end_d      = heap_end_q;
    res_d           = res_q;
    ram_req_o       = '0;
    ram_req_o.raddr = '0;
    unique case (state_q)
      S_INIT: begin
        heap_end_d = heap_base_i;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d      = in_opcode_i;
          operand_d = in_operand_i;
          idx_d     = '0;
        end
      end
      S_SCAN: begin
        // read of the next entry overlaps the compare of this one
        ram_req_o.raddr = idx_q + IDX_W'(1);
        if (hit) begin
          ram_req_o.we            = 1'b1;
          ram_req_o.waddr         = idx_q;
          ram_req_o.wdata         = ram_rdata_i;
          ram_req_o.wdata.free    = (op_q == OP_FREE);
          res_d.status            = STAT_OK;
          res_d.addr              = (op_q == OP_ALLOC) ? ram_rdata_i.address : '0;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_MISS: begin
        res_d.addr = '0;
        if (op_q == OP_FREE) begin
          res_d.status = STAT_NOT_FOUND;
        end else if (full) begin
          res_d.status = STAT_FULL;
        end else begin
          ram_req_o.we            = 1'b1;
          ram_req_o.waddr         = count_q[IDX_W-1:0];
          ram_req_o.wdata.free    = 1'b0;
          ram_req_o.wdata.size    = operand_q;
          ram_req_o.wdata.address = heap_end_q;
          count_d                 = count_q + CNT_W'(1);
          heap_end_d              = heap_end_q + operand_q;
          res_d.addr              = heap_end_q;
          res_d.status            = STAT_OK;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    operand_q  <= operand_d;
    idx_q      <= idx_d;
    heap_end_q <= heap_end_d;
    res_q      <= res_d;
  end

  assign res_o = res_q;

endmodule

// ----- sv/block_table_heap_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_table_heap_allocator_top
// first-fit heap allocator over a small block table
// ----------------------------------------------------------------------------
// Handles one request at a time. An allocate or free walks the block table
// from entry 0, comparing one entry per cycle from a memory whose read is
// pipelined against the compare, and stops at the first hit or after the
// last valid entry. The result sits in an output register, so the next
// request is taken while it waits. After reset the block loads the heap end
// from heap_base in its init state before it accepts a request; a heap_base
// write changes only the register, and reset clears that register along
// with the table.
module block_table_heap_allocator_top import bth_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [ADDR_W-1:0]  cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // [38:0] operand
  input  logic               s_axis_tuser,   // [0] opcode
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // [38:0] block_address
  output logic [1:0]         m_axis_tuser    // [1:0] status
);

  logic [ADDR_W-1:0] heap_base_q;
  logic              out_valid_q;
  result_t           out_q;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  ram_req_t          ram_req;
  logic [ENTRY_W-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
    end else if (cfg_we_i) begin
      heap_base_q <= cfg_wdata_i;
    end
  end

  bth_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .heap_base_i  (heap_base_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_opcode_i  (opcode_e'(s_axis_tuser)),
    .in_operand_i (s_axis_tdata[ADDR_W-1:0]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (entry_t'(ram_rdata))
  );

  bth_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // output word register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_q.addr);
  assign m_axis_tuser  = out_q.status;

endmodule

// ----- sv/bth_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_checker
// port level checks of the heap allocator
// ----------------------------------------------------------------------------
module bth_checker import bth_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]         m_axis_tuser
);

  // no defined status code beyond not found
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_FULL ||
                       m_axis_tuser == STAT_NOT_FOUND))
    else $error("undefined status code");

  // failed requests return no address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != STAT_OK) |-> (m_axis_tdata == '0))
    else $error("failed request returned an address");

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
                                           && $stable(m_axis_tuser)))
    else $error("output word changed while stalled");

  // one request in flight: nothing accepted in the cycle right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in work");

endmodule

bind block_table_heap_allocator_top bth_checker u_bth_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/tb_block_table_heap_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_table_heap_allocator_top
// self-checking bench for the first-fit block table heap allocator
// ----------------------------------------------------------------------------
// Requests go in on the slave stream and replies come back on the master
// stream. A behavioral copy of the block table (addresses, sizes, free flags,
// row count and heap end) predicts every reply, and each reply is checked
// field by field in order. A short directed run covers reuse, double free,
// duplicate addresses, zero size, heap end wrap and a full table. Random
// traffic then mostly frees known blocks and allocates sizes that fit them,
// with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_block_table_heap_allocator_top;
  import bth_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int BURST_HOLD  = 300;
  localparam int IN_FLIGHT   = 4;

  typedef struct {
    opcode_e           op;
    logic [ADDR_W-1:0] operand;
  } heap_req_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    status_e           status;
  } heap_rsp_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [ADDR_W-1:0]  cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;  // [38:0] operand
  logic               s_axis_tuser  = 1'b0; // [0] opcode
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;        // [38:0] block_address
  logic [1:0]         m_axis_tuser;        // [1:0] status

  block_table_heap_allocator_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow of the block table
  logic [ADDR_W-1:0] row_addr [TABLE_DEPTH];
  logic [ADDR_W-1:0] row_size [TABLE_DEPTH];
  bit                row_free [TABLE_DEPTH];
  int                rows_used      = 0;
  logic [ADDR_W-1:0] heap_top       = '0;
  logic [ADDR_W-1:0] heap_base_copy = '0;

  heap_req_t requests_waiting[$];
  heap_rsp_t replies_due[$];

  int error_count = 0;
  int cycle_count = 0;
  bit req_fire    = 1'b0;
  int send_gap    = 0;
  int hold_left   = 0;
  int burst_req   = 0;
  int burst_seen  = 0;
  bit sender_idle = 1'b1;
  bit recv_idle   = 1'b1;

  function automatic heap_rsp_t apply_heap_request(heap_req_t r);
    heap_rsp_t rsp;
    bit        hit;
    rsp.addr   = '0;
    rsp.status = STAT_OK;
    hit        = 1'b0;
    if (r.op == OP_ALLOC) begin
      for (int i = 0; i < rows_used && !hit; i++) begin
        if (row_free[i] && row_size[i] >= r.operand) begin
          row_free[i] = 1'b0;
          rsp.addr    = row_addr[i];
          hit         = 1'b1;
        end
      end
      if (!hit) begin
        if (rows_used >= TABLE_DEPTH) begin
          rsp.status = STAT_FULL;
        end else begin
          row_addr[rows_used] = heap_top;
          row_size[rows_used] = r.operand;
          row_free[rows_used] = 1'b0;
          rows_used++;
          rsp.addr = heap_top;
          heap_top = heap_top + r.operand; // wraps at the address width
        end
      end
    end else begin
      rsp.status = STAT_NOT_FOUND;
      for (int i = 0; i < rows_used && !hit; i++) begin
        if (row_addr[i] == r.operand) begin
          row_free[i] = 1'b1;
          rsp.status  = STAT_OK;
          hit         = 1'b1;
        end
      end
    end
    return rsp;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[ADDR_W-1:0];
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic heap_req_t random_request();
    heap_req_t r;
    int        pick;
    int        row;
    pick = $urandom_range(0, 99);
    row  = (rows_used > 0) ? $urandom_range(0, rows_used - 1) : 0;
    r.op      = OP_ALLOC;
    r.operand = ADDR_W'($urandom_range(0, 64));
    if (rows_used == 0) return r;
    if (pick < 35) begin
      r.op      = OP_FREE;
      r.operand = row_addr[row];
    end else if (pick < 70) begin
      r.operand = row_size[row] >> $urandom_range(0, 3);
    end else if (pick < 80) begin
      r.operand = ADDR_W'($urandom_range(0, 64));
    end else if (pick < 88) begin
      r.operand = rand_addr();
    end else if (pick < 95) begin
      r.op      = OP_FREE;
      r.operand = rand_addr();
    end else begin
      r.op      = opcode_e'($urandom_range(0, 1));
      r.operand = '1;
    end
    return r;
  endfunction

  task automatic queue_request(opcode_e op, logic [ADDR_W-1:0] operand);
    heap_req_t r;
    r.op      = op;
    r.operand = operand;
    requests_waiting.push_back(r);
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      while (requests_waiting.size() >= IN_FLIGHT) @(posedge clk_i);
      // quiet stretches with no idling on either side
      sender_idle = (n % 100) < 75;
      recv_idle   = (n % 100) < 75;
      requests_waiting.push_back(random_request());
    end
  endtask

  task automatic wait_drained();
    while (requests_waiting.size() != 0 || s_axis_tvalid || replies_due.size() != 0)
      @(negedge clk_i);
    repeat (25) @(negedge clk_i);
  endtask

  task automatic write_heap_base(logic [ADDR_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    heap_base_copy = value; // reset clears the register, so the heap end never loads this value
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // request acceptance and prediction
  always @(posedge clk_i) begin
    heap_req_t r;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      r.op      = opcode_e'(s_axis_tuser);
      r.operand = s_axis_tdata[ADDR_W-1:0];
      replies_due.push_back(apply_heap_request(r));
      req_fire <= 1'b1;
    end else begin
      req_fire <= 1'b0;
    end
  end

  // request driver
  always @(negedge clk_i) begin
    heap_req_t r;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !req_fire) begin
      s_axis_tvalid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap      <= send_gap - 1;
      s_axis_tvalid <= 1'b0;
    end else if (requests_waiting.size() != 0) begin
      r = requests_waiting.pop_front();
      s_axis_tdata  <= TDATA_W'(r.operand);
      s_axis_tuser  <= r.op;
      s_axis_tvalid <= 1'b1;
      send_gap      <= sender_idle ? pick_gap() : 0;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // reply ready with random stalls and one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (burst_seen != burst_req) begin
      burst_seen    <= burst_seen + 1;
      hold_left     <= BURST_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 99) < 25) begin
      hold_left     <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // reply checker
  always @(posedge clk_i) begin
    heap_rsp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        $error("unexpected word: block_address %0h status %0d",
               m_axis_tdata[ADDR_W-1:0], m_axis_tuser);
        error_count++;
      end else begin
        want = replies_due.pop_front();
        if (m_axis_tdata[ADDR_W-1:0] !== want.addr) begin
          $error("block_address: expected %0h actual %0h",
                 want.addr, m_axis_tdata[ADDR_W-1:0]);
          error_count++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni   <= 1'b1;
    heap_top = heap_base_copy;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    write_heap_base('1);

    // zero size, double free and duplicate address at 0
    queue_request(OP_ALLOC, '0);
    queue_request(OP_FREE, '0);
    queue_request(OP_FREE, '0);
    queue_request(OP_ALLOC, 39'd5);
    queue_request(OP_FREE, '0);
    queue_request(OP_ALLOC, '0);
    queue_request(OP_FREE, 39'd123);
    // largest size wraps the heap end
    queue_request(OP_ALLOC, '1);
    queue_request(OP_ALLOC, 39'd16);
    queue_request(OP_FREE, '1);
    queue_request(OP_FREE, 39'd5);
    queue_request(OP_ALLOC, 39'd100);
    // fill the table, then overflow it
    for (int i = 0; i < 12; i++) queue_request(OP_ALLOC, 39'd8);
    queue_request(OP_ALLOC, 39'd8);
    queue_request(OP_FREE, 39'd20);
    queue_request(OP_ALLOC, 39'd8);
    wait_drained();

    run_random(280);
    wait_drained();
    write_heap_base(rand_addr());

    burst_req++;
    run_random(280);
    wait_drained();
    write_heap_base('0);

    run_random(270);
    wait_drained();

    if (error_count == 0 && replies_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/bth_pkg.sv
sv/bth_ram.sv
sv/bth_ctrl.sv
sv/block_table_heap_allocator_top.sv
sv/bth_checker.sv
tb/tb_block_table_heap_allocator_top.sv
